### design/knsl_pkg.sv
// Shared codes and cell interface types for the sorted k-nearest list.
package knsl_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] OUT_INSERTED  = 2'd0;
    localparam logic [1:0] OUT_DUPLICATE = 2'd1;
    localparam logic [1:0] OUT_DROPPED   = 2'd2;
    localparam logic [1:0] OUT_DONE      = 2'd3;

    localparam int DIST_W    = 32;
    localparam int ID_PORT_W = 16;
    localparam int LIMIT_W   = 5;
    localparam int RIDX_W    = 4;
    localparam int SLOT_W    = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // per-cell update command
    typedef struct packed {
        logic load_new;   // take the candidate
        logic shift;      // take the left neighbor's entry
    } cell_ctl_t;

    // per-cell scan result
    typedef struct packed {
        logic at_slot;    // first cell where the scan stops
        logic dup;        // scan stopped here on a matching id
    } cell_stat_t;

endpackage

### design/knsl_cell.sv
// One list position: entry storage, compare flags and the scan chain link.
module knsl_cell #(
    parameter int ID_W = 16
) (
    input  logic                         clk,
    input  logic [ID_W-1:0]              cand_id,
    input  logic [knsl_pkg::DIST_W-1:0]  cand_dist,
    input  logic [ID_W-1:0]              prev_id,
    input  logic [knsl_pkg::DIST_W-1:0]  prev_dist,
    input  knsl_pkg::cell_ctl_t          ctl,
    input  logic                         vld,
    input  logic                         pass_in,
    output logic                         pass_out,
    output knsl_pkg::cell_stat_t         stat,
    output logic [ID_W-1:0]              cell_id,
    output logic [knsl_pkg::DIST_W-1:0]  cell_dist
);

    logic [ID_W-1:0]             id_reg;
    logic [knsl_pkg::DIST_W-1:0] dist_reg;
    logic                        le_reg;
    logic                        hit_reg;
    logic                        stop;

    always_ff @(posedge clk)
    begin
        le_reg  <= (cand_dist >= dist_reg);
        hit_reg <= (cand_id == id_reg);
        if (ctl.load_new)
        begin
            id_reg   <= cand_id;
            dist_reg <= cand_dist;
        end
        else if (ctl.shift)
        begin
            id_reg   <= prev_id;
            dist_reg <= prev_dist;
        end
    end

    // scan stops past the count, at a farther entry, or on a matching id
    assign stop         = !(vld && le_reg) || hit_reg;
    assign pass_out     = pass_in && !stop;
    assign stat.at_slot = pass_in && stop;
    assign stat.dup     = pass_in && vld && le_reg && hit_reg;
    assign cell_id      = id_reg;
    assign cell_dist    = dist_reg;

endmodule

### design/k_nearest_sorted_list_insert_core.sv
// Top level of the sorted k-nearest-neighbor insertion list.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | in_valid / in_stall     | kind, distance, point_id, read_index
//  out     | output    | out_valid / out_stall   | outcome, slot, count, entry_id,
//          |           |                         | entry_distance
//  cfg     | input     | cfg_valid / cfg_ready   | cfg_data (max_neighbours)
//
// An item passes through two steps: a compare step (ST_EVAL), in which every
// cell compares its entry with the candidate and registers the flags, and a
// commit step (ST_COMMIT) that runs the scan chain and shifts/writes the cells.
// The next item is taken in the commit step, while the last one is finishing.
// Reset clears the count and sets the limit to 16; entry storage is not
// cleared since only positions below the count are ever read.
// A stalled result holds the commit step until the output register frees.
//
// The entries live in a row of cells. Every cell compares in parallel;
// a pass signal ripples from cell 0 and marks the first cell where the
// scan stops (entry past the count, farther entry, or same id). That cell
// is the slot; cells behind it up to min(count, limit-1) take their left
// neighbor's entry, and the slot cell takes the candidate.
module k_nearest_sorted_list_insert_core #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [knsl_pkg::DIST_W-1:0]     distance,
    input  logic [knsl_pkg::ID_PORT_W-1:0]  point_id,
    input  logic [knsl_pkg::RIDX_W-1:0]     read_index,
    // results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      outcome,
    output logic [knsl_pkg::SLOT_W-1:0]     slot,
    output logic [knsl_pkg::SLOT_W-1:0]     count,
    output logic [knsl_pkg::ID_PORT_W-1:0]  entry_id,
    output logic [knsl_pkg::DIST_W-1:0]     entry_distance,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [knsl_pkg::LIMIT_W-1:0]    cfg_data
);

    localparam int ID_W  = (ID_BITS < knsl_pkg::ID_PORT_W) ? ID_BITS : knsl_pkg::ID_PORT_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_COMMIT} state_t;

    state_t                        state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [knsl_pkg::LIMIT_W-1:0]  limit_cfg_reg;

    // captured item
    logic [1:0]                    kind_reg;
    logic [knsl_pkg::DIST_W-1:0]   dist_reg;
    logic [ID_W-1:0]               id_reg;
    logic [knsl_pkg::RIDX_W-1:0]   ridx_reg;

    // result register
    logic [1:0]                    outcome_reg, outcome_next;
    logic [knsl_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [knsl_pkg::SLOT_W-1:0]   count_out_reg;
    logic [knsl_pkg::ID_PORT_W-1:0] eid_reg, eid_next;
    logic [knsl_pkg::DIST_W-1:0]   edist_reg, edist_next;

    // cell row
    knsl_pkg::cell_ctl_t           ctl  [CAPACITY];
    knsl_pkg::cell_stat_t          stat [CAPACITY];
    logic [ID_W-1:0]               cell_id   [CAPACITY];
    logic [knsl_pkg::DIST_W-1:0]   cell_dist [CAPACITY];
    logic [ID_W-1:0]               prev_id   [CAPACITY];
    logic [knsl_pkg::DIST_W-1:0]   prev_dist [CAPACITY];
    logic [CAPACITY-1:0]           vld;
    logic [CAPACITY:0]             pass;

    logic                          accept;
    logic                          fire;
    logic [CNT_W-1:0]              limit;
    logic                          dup;
    logic                          room;
    logic                          do_ins;
    logic [CNT_W-1:0]              slot_k;

    assign accept    = in_valid && !in_stall;
    assign fire      = (state_reg == ST_COMMIT) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != ST_IDLE) && !fire;
    assign cfg_ready = 1'b1;

    // limit above capacity acts as capacity
    assign limit = (int'(limit_cfg_reg) > CAPACITY) ? CNT_W'(CAPACITY) : CNT_W'(limit_cfg_reg);

    assign pass[0] = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign vld[i] = (int'(count_reg) > i);
        if (i == 0)
        begin : g_head
            assign prev_id[i]   = id_reg;
            assign prev_dist[i] = dist_reg;
        end
        else
        begin : g_body
            assign prev_id[i]   = cell_id[i-1];
            assign prev_dist[i] = cell_dist[i-1];
        end
        // cells between the slot and min(count, limit-1) move back by one
        assign ctl[i].load_new = do_ins && stat[i].at_slot;
        assign ctl[i].shift    = do_ins && !pass[i] && (int'(count_reg) >= i) &&
                                 (int'(limit) > i);

        knsl_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .clk       (clk),
            .cand_id   (id_reg),
            .cand_dist (dist_reg),
            .prev_id   (prev_id[i]),
            .prev_dist (prev_dist[i]),
            .ctl       (ctl[i]),
            .vld       (vld[i]),
            .pass_in   (pass[i]),
            .pass_out  (pass[i+1]),
            .stat      (stat[i]),
            .cell_id   (cell_id[i]),
            .cell_dist (cell_dist[i])
        );
    end

    // slot encode and duplicate / room detection from the one-hot stop mark
    always_comb
    begin
        dup    = 1'b0;
        room   = 1'b0;
        slot_k = pass[CAPACITY] ? CNT_W'(CAPACITY) : '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            dup = dup | stat[i].dup;
            if (stat[i].at_slot)
            begin
                slot_k = slot_k | CNT_W'(i);
                if (int'(limit) > i)
                    room = 1'b1;
            end
        end
    end

    assign do_ins = fire && (kind_reg == knsl_pkg::KIND_INSERT) && !dup && room;

    always_comb
    begin
        count_next     = count_reg;
        outcome_next   = knsl_pkg::OUT_DONE;
        slot_next      = '0;
        eid_next       = '0;
        edist_next     = '0;
        out_valid_next = out_valid_reg && out_stall;
        state_next     = state_reg;

        unique case (kind_reg)
            knsl_pkg::KIND_INSERT:
            begin
                slot_next = knsl_pkg::SLOT_W'(slot_k);
                if (dup)
                    outcome_next = knsl_pkg::OUT_DUPLICATE;
                else if (!room)
                    outcome_next = knsl_pkg::OUT_DROPPED;
                else
                begin
                    outcome_next = knsl_pkg::OUT_INSERTED;
                    if (count_reg < limit)
                        count_next = count_reg + 1'b1;
                end
            end
            knsl_pkg::KIND_READ:
            begin
                slot_next = knsl_pkg::SLOT_W'(ridx_reg);
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if ((int'(ridx_reg) == i) && vld[i])
                    begin
                        eid_next[ID_W-1:0] = cell_id[i];
                        edist_next         = cell_dist[i];
                    end
                end
            end
            knsl_pkg::KIND_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        if (!fire)
            count_next = count_reg;
        else
            out_valid_next = 1'b1;

        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (fire)
                    state_next = accept ? ST_EVAL : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            limit_cfg_reg <= knsl_pkg::LIMIT_RESET;
            kind_reg      <= '0;
            dist_reg      <= '0;
            id_reg        <= '0;
            ridx_reg      <= '0;
            outcome_reg   <= '0;
            slot_reg      <= '0;
            count_out_reg <= '0;
            eid_reg       <= '0;
            edist_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_valid && cfg_ready)
                limit_cfg_reg <= cfg_data;
            if (accept)
            begin
                kind_reg <= kind;
                dist_reg <= distance;
                id_reg   <= point_id[ID_W-1:0];
                ridx_reg <= read_index;
            end
            if (fire)
            begin
                outcome_reg   <= outcome_next;
                slot_reg      <= slot_next;
                count_out_reg <= knsl_pkg::SLOT_W'(count_next);
                eid_reg       <= eid_next;
                edist_reg     <= edist_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign slot           = slot_reg;
    assign count          = count_out_reg;
    assign entry_id       = eid_reg;
    assign entry_distance = edist_reg;

endmodule

### design/knsl_checker.sv
// Port-level checks for the sorted k-nearest list, bound to the top level.
module knsl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [1:0]                      outcome,
    input logic [knsl_pkg::SLOT_W-1:0]     slot,
    input logic [knsl_pkg::SLOT_W-1:0]     count,
    input logic [knsl_pkg::ID_PORT_W-1:0]  entry_id,
    input logic [knsl_pkg::DIST_W-1:0]     entry_distance
);

    // a waiting result stays until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a transferred item holds the input off for its compare cycle
    a_eval_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken during compare cycle");

    // an inserted entry lies inside the list
    a_insert_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == knsl_pkg::OUT_INSERTED) |-> (count != 0) && (slot < count))
        else $error("insert slot outside list");

    // inserts report no entry data
    a_insert_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome != knsl_pkg::OUT_DONE) |-> (entry_id == 0) &&
        (entry_distance == 0))
        else $error("entry data on insert result");

endmodule

bind k_nearest_sorted_list_insert_core knsl_checker u_knsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .slot           (slot),
    .count          (count),
    .entry_id       (entry_id),
    .entry_distance (entry_distance)
);

### test/tb_top.sv
// Self-checking testbench for the sorted k-nearest-neighbor insertion list.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP    = 16;
    localparam int HOLD_CYCLES = 60;   // long output hold-off, fills the block
    localparam int PHASE_ITEMS = 250;
    localparam int REPORT_MAX  = 10;

    // kind code the block must treat as a no-op
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]                     kind;
        logic [knsl_pkg::DIST_W-1:0]    distance;
        logic [knsl_pkg::ID_PORT_W-1:0] point_id;
        logic [knsl_pkg::RIDX_W-1:0]    read_index;
    } knn_item_t;

    typedef struct packed {
        logic [1:0]                     outcome;
        logic [knsl_pkg::SLOT_W-1:0]    slot;
        logic [knsl_pkg::SLOT_W-1:0]    count;
        logic [knsl_pkg::ID_PORT_W-1:0] entry_id;
        logic [knsl_pkg::DIST_W-1:0]    entry_distance;
    } knn_result_t;

    typedef enum logic { ROW_ITEM, ROW_LIMIT } row_op_t;

    // directed row: an item (optionally with a hand-written result) or a limit write
    typedef struct {
        row_op_t                      op;
        logic [knsl_pkg::LIMIT_W-1:0] limit;
        knn_item_t                    item;
        bit                           typed;
        knn_result_t                  result;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [1:0]                     kind = '0;
    logic [knsl_pkg::DIST_W-1:0]    distance = '0;
    logic [knsl_pkg::ID_PORT_W-1:0] point_id = '0;
    logic [knsl_pkg::RIDX_W-1:0]    read_index = '0;

    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     outcome;
    logic [knsl_pkg::SLOT_W-1:0]    slot;
    logic [knsl_pkg::SLOT_W-1:0]    count;
    logic [knsl_pkg::ID_PORT_W-1:0] entry_id;
    logic [knsl_pkg::DIST_W-1:0]    entry_distance;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [knsl_pkg::LIMIT_W-1:0]   cfg_data = '0;

    // shadow copy of the list
    logic [knsl_pkg::ID_PORT_W-1:0] shadow_ids [LIST_CAP];
    logic [knsl_pkg::DIST_W-1:0]    shadow_dists [LIST_CAP];
    int unsigned                    shadow_count = 0;
    logic [knsl_pkg::LIMIT_W-1:0]   shadow_limit = knsl_pkg::LIMIT_RESET;

    knn_result_t pending_results [$];
    int          mismatches = 0;

    int idle_pct = 0;     // sender idle chance per cycle
    int stall_pct = 0;    // receiver stall chance per cycle
    bit hold_req = 1'b0;  // asks the receiver for a long hold-off
    int hold_left = 0;

    k_nearest_sorted_list_insert_core #(
        .CAPACITY (LIST_CAP),
        .ID_BITS  (16)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .distance       (distance),
        .point_id       (point_id),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .slot           (slot),
        .count          (count),
        .entry_id       (entry_id),
        .entry_distance (entry_distance),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one item to the shadow list and returns the result it yields.
    function automatic knn_result_t apply_to_list(input knn_item_t it);
        knn_result_t r;
        int unsigned lim;
        int unsigned k;
        int unsigned top;
        int unsigned l;
        bit          hit;
        r = '0;
        r.outcome = knsl_pkg::OUT_DONE;
        lim = (shadow_limit > LIST_CAP) ? LIST_CAP : shadow_limit;
        unique case (it.kind)
            knsl_pkg::KIND_INSERT:
            begin
                // scan entries no farther than the candidate, stop on a same id
                k = 0;
                hit = 1'b0;
                while (k < shadow_count && k < LIST_CAP && it.distance >= shadow_dists[k])
                begin
                    if (shadow_ids[k] == it.point_id)
                    begin
                        hit = 1'b1;
                        break;
                    end
                    k++;
                end
                r.slot = knsl_pkg::SLOT_W'(k);
                if (hit)
                    r.outcome = knsl_pkg::OUT_DUPLICATE;
                else if (k >= lim)
                    r.outcome = knsl_pkg::OUT_DROPPED;
                else
                begin
                    // shift only below the limit; the tail entry falls off when full
                    top = (shadow_count < lim - 1) ? shadow_count : lim - 1;
                    for (l = top; l > k; l--)
                    begin
                        shadow_ids[l] = shadow_ids[l - 1];
                        shadow_dists[l] = shadow_dists[l - 1];
                    end
                    shadow_ids[k] = it.point_id;
                    shadow_dists[k] = it.distance;
                    if (shadow_count < lim)
                        shadow_count++;
                    r.outcome = knsl_pkg::OUT_INSERTED;
                end
            end
            knsl_pkg::KIND_READ:
            begin
                r.slot = knsl_pkg::SLOT_W'(it.read_index);
                if (it.read_index < shadow_count)
                begin
                    r.entry_id = shadow_ids[it.read_index];
                    r.entry_distance = shadow_dists[it.read_index];
                end
            end
            knsl_pkg::KIND_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        r.count = knsl_pkg::SLOT_W'(shadow_count);
        return r;
    endfunction

    function automatic script_row_t op_row(input logic [1:0] k,
                                           input logic [knsl_pkg::DIST_W-1:0] d,
                                           input logic [knsl_pkg::ID_PORT_W-1:0] id,
                                           input logic [knsl_pkg::RIDX_W-1:0] ridx);
        script_row_t row;
        row.op = ROW_ITEM;
        row.limit = '0;
        row.item = '{k, d, id, ridx};
        row.typed = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic script_row_t with_result(input script_row_t row, input logic [1:0] oc,
                                                input int s, input int c,
                                                input logic [knsl_pkg::ID_PORT_W-1:0] eid,
                                                input logic [knsl_pkg::DIST_W-1:0] ed);
        row.typed = 1'b1;
        row.result = '{oc, knsl_pkg::SLOT_W'(s), knsl_pkg::SLOT_W'(c), eid, ed};
        return row;
    endfunction

    function automatic script_row_t limit_row(input logic [knsl_pkg::LIMIT_W-1:0] v);
        script_row_t row;
        row.op = ROW_LIMIT;
        row.limit = v;
        row.item = '0;
        row.typed = 1'b0;
        row.result = '0;
        return row;
    endfunction

    // Mostly well-formed list traffic: clustered distances and a small id pool
    // so that duplicates, ties and full lists are common; the rest is raw noise.
    function automatic knn_item_t random_item();
        knn_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            it.kind = knsl_pkg::KIND_INSERT;
        else if (pick < 88)
            it.kind = knsl_pkg::KIND_READ;
        else if (pick < 92)
            it.kind = knsl_pkg::KIND_CLEAR;
        else if (pick < 95)
            it.kind = KIND_NONE;
        else
            it.kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 65)
            it.distance = knsl_pkg::DIST_W'($urandom_range(0, 48)) << 10;
        else
            it.distance = $urandom();
        if ($urandom_range(0, 99) < 70)
            it.point_id = knsl_pkg::ID_PORT_W'($urandom_range(0, 23));
        else
            it.point_id = knsl_pkg::ID_PORT_W'($urandom_range(0, 65535));
        it.read_index = knsl_pkg::RIDX_W'($urandom_range(0, 15));
        return it;
    endfunction

    // Offers one item after a random idle gap and records its expected result.
    task automatic send_item(input knn_item_t it, input bit typed, input knn_result_t given);
        int          gap;
        knn_result_t r;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= it.kind;
        distance   <= it.distance;
        point_id   <= it.point_id;
        read_index <= it.read_index;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_to_list(it);
        if (typed)
            r = given;
        pending_results = {pending_results, r};
    endtask

    // Stops offering and waits until every result is out, plus the pipe depth.
    task automatic drain_list_pipe();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [knsl_pkg::LIMIT_W-1:0] v);
        drain_list_pipe();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_limit = v;
    endtask

    task automatic flag_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // Result side: check every transfer, then decide the next stall.
    always @(posedge clk)
    begin
        knn_result_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with nothing outstanding, outcome %0h slot %0h",
                             $realtime, outcome, slot);
            end
            else
            begin
                want = pending_results.pop_front();
                flag_field("outcome", want.outcome, outcome);
                flag_field("slot", want.slot, slot);
                flag_field("count", want.count, count);
                flag_field("entry_id", want.entry_id, entry_id);
                flag_field("entry_distance", want.entry_distance, entry_distance);
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        script_row_t script [$];
        int          phase_idle [4];
        int          phase_stall [4];
        int          ph;
        int          n;
        knn_item_t   it;

        phase_idle  = '{0, 46, 0, 16};
        phase_stall = '{0, 0, 46, 16};

        // directed walk: extremes, every kind, ties, duplicates and the limit corners
        script = '{
            with_result(op_row(knsl_pkg::KIND_READ, 32'd0, 16'd0, 4'd0),
                        knsl_pkg::OUT_DONE, 0, 0, 16'd0, 32'd0),
            with_result(op_row(KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF, 4'hF),
                        knsl_pkg::OUT_DONE, 0, 0, 16'd0, 32'd0),
            with_result(op_row(knsl_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 4'd0),
                        knsl_pkg::OUT_INSERTED, 0, 1, 16'd0, 32'd0),
            with_result(op_row(knsl_pkg::KIND_INSERT, 32'd0, 16'd0, 4'hF),
                        knsl_pkg::OUT_INSERTED, 0, 2, 16'd0, 32'd0),
            with_result(op_row(knsl_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 4'd0),
                        knsl_pkg::OUT_DUPLICATE, 1, 2, 16'd0, 32'd0),
            op_row(knsl_pkg::KIND_INSERT, 32'h8000_0000, 16'h1234, 4'd0),
            op_row(knsl_pkg::KIND_INSERT, 32'h8000_0000, 16'h5678, 4'd0),   // tie lands behind
            with_result(op_row(knsl_pkg::KIND_READ, 32'd0, 16'd0, 4'hF),
                        knsl_pkg::OUT_DONE, 15, 4, 16'd0, 32'd0),
            op_row(knsl_pkg::KIND_READ, 32'd0, 16'd0, 4'd1),
            limit_row(5'd31),                                               // above capacity
            op_row(knsl_pkg::KIND_INSERT, 32'd3, 16'h00AA, 4'd0),
            limit_row(5'd2),                                                // below the count
            op_row(knsl_pkg::KIND_INSERT, 32'd1, 16'd7, 4'd0),
            op_row(knsl_pkg::KIND_INSERT, 32'hFFFF_FFF0, 16'd8, 4'd0),
            op_row(knsl_pkg::KIND_READ, 32'd0, 16'd0, 4'd3),                // past the limit
            limit_row(5'd0),
            op_row(knsl_pkg::KIND_INSERT, 32'd0, 16'd0, 4'd0),
            with_result(op_row(knsl_pkg::KIND_CLEAR, 32'd9, 16'd9, 4'd9),
                        knsl_pkg::OUT_DONE, 0, 0, 16'd0, 32'd0),
            with_result(op_row(knsl_pkg::KIND_INSERT, 32'd0, 16'd1, 4'd0),
                        knsl_pkg::OUT_DROPPED, 0, 0, 16'd0, 32'd0),
            limit_row(5'd1),
            with_result(op_row(knsl_pkg::KIND_INSERT, 32'd100, 16'd2, 4'd0),
                        knsl_pkg::OUT_INSERTED, 0, 1, 16'd0, 32'd0),
            op_row(knsl_pkg::KIND_INSERT, 32'd50, 16'd3, 4'd0),
            op_row(knsl_pkg::KIND_INSERT, 32'd200, 16'd4, 4'd0),
            limit_row(knsl_pkg::LIMIT_RESET),
            with_result(op_row(knsl_pkg::KIND_CLEAR, 32'd0, 16'd0, 4'd0),
                        knsl_pkg::OUT_DONE, 0, 0, 16'd0, 32'd0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].op == ROW_LIMIT)
                write_limit(script[i].limit);
            else
                send_item(script[i].item, script[i].typed, script[i].result);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0: write_limit(knsl_pkg::LIMIT_RESET);
                1: write_limit(knsl_pkg::LIMIT_W'($urandom_range(1, 8)));
                2: write_limit(knsl_pkg::LIMIT_W'($urandom_range(17, 31)));
                default: write_limit(knsl_pkg::LIMIT_W'($urandom_range(0, 31)));
            endcase
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while items keep coming
                if (ph == 0 && n == 100)
                    hold_req = 1'b1;
                // sender pauses until the block has delivered everything
                if (n == PHASE_ITEMS / 2)
                    drain_list_pipe();
                it = random_item();
                send_item(it, 1'b0, '0);
            end
        end

        drain_list_pipe();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### k_nearest_sorted_list_insert_core.f
design/knsl_pkg.sv
design/knsl_cell.sv
design/k_nearest_sorted_list_insert_core.sv
design/knsl_checker.sv
test/tb_top.sv
